// ===== hw/rtl/ellipse_fan_ring_vertex_gen_unit_defines.svh =====
// assertion helpers for the ellipse fan vertex generator
`ifndef ELLIPSE_FAN_RING_VERTEX_GEN_UNIT_DEFINES_SVH
`define ELLIPSE_FAN_RING_VERTEX_GEN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define EFR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("efr check failed");

// same-cycle implication
`define EFR_ASSERT_IMPL(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("efr implication failed");

// next-cycle implication
`define EFR_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("efr sequence failed");

`else

`define EFR_ASSERT(label, prop)
`define EFR_ASSERT_IMPL(label, cond, conseq)
`define EFR_ASSERT_NEXT(label, cond, conseq)

`endif

`endif

// ===== hw/rtl/efr_pkg.sv =====
`timescale 1ns / 1ps

package efr_pkg;

    localparam int MAX_SEGMENTS_DEF  = 256;
    localparam int CORDIC_STAGES_DEF = 16;

    // cordic datapath width, q30 values plus headroom and sign
    localparam int CORDIC_W = 33;

    localparam logic [31:0] GAIN_Q30    = 32'd652032874;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // shared divider
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 16;

    localparam logic [15:0] SEMI_WIDTH_RST    = 16'd12800;
    localparam logic [15:0] SEMI_HEIGHT_RST   = 16'd12800;
    localparam logic [8:0]  SEGMENT_COUNT_RST = 9'd32;
    localparam logic [12:0] FADE_BORDER_RST   = 13'd0;
    localparam logic [15:0] DEPTH_VALUE_RST   = 16'd0;

    typedef enum logic [2:0] {
        CFG_SEMI_WIDTH,
        CFG_SEMI_HEIGHT,
        CFG_SEGMENT_COUNT,
        CFG_FADE_BORDER,
        CFG_DEPTH_VALUE
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PRODUCT,
        ST_FILL,
        ST_RUN
    } setup_state_t;

    typedef enum logic [2:0] {
        JOB_STEP,
        JOB_ASPECT,
        JOB_TWO_B,
        JOB_ADJ_X,
        JOB_ADJ_Y
    } div_job_t;

    typedef struct packed {
        logic       bad;
        logic       center;
        logic       outer;
        logic [1:0] quad;
    } vtx_ctl_t;

    function automatic logic [31:0] atan_q30(input int unsigned k);
        logic [31:0] a;
        case (k)
            0:       a = 32'd843314857;
            1:       a = 32'd497837829;
            2:       a = 32'd263043837;
            3:       a = 32'd133525159;
            4:       a = 32'd67021687;
            5:       a = 32'd33543516;
            6:       a = 32'd16775851;
            7:       a = 32'd8388437;
            8:       a = 32'd4194283;
            9:       a = 32'd2097149;
            10:      a = 32'd1048576;
            11:      a = 32'd524288;
            12:      a = 32'd262144;
            13:      a = 32'd131072;
            14:      a = 32'd65536;
            15:      a = 32'd32768;
            16:      a = 32'd16384;
            17:      a = 32'd8192;
            18:      a = 32'd4096;
            19:      a = 32'd2048;
            20:      a = 32'd1024;
            21:      a = 32'd512;
            22:      a = 32'd256;
            23:      a = 32'd128;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/efr_ram.sv =====
`timescale 1ns / 1ps

module efr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/efr_div.sv =====
`timescale 1ns / 1ps

module efr_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [efr_pkg::DIV_NUM_W-1:0]  num,
    input  logic [efr_pkg::DIV_DEN_W-1:0]  den,
    output logic                           done,
    output logic [efr_pkg::DIV_NUM_W-1:0]  quot,
    output logic [efr_pkg::DIV_DEN_W-1:0]  rem
);

    import efr_pkg::*;

    localparam int CW = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] acc_reg, acc_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted  = {rem_reg, acc_reg[DIV_NUM_W-1]};
        diff     = shifted - {1'b0, den_reg};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
        acc_next = {acc_reg[DIV_NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_NUM_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = acc_reg;
    assign rem  = rem_reg;

endmodule

// ===== hw/rtl/efr_cordic_cell.sv =====
`timescale 1ns / 1ps

module efr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                up_valid,
    output logic                                up_ready,
    input  logic signed [efr_pkg::CORDIC_W-1:0] up_x,
    input  logic signed [efr_pkg::CORDIC_W-1:0] up_y,
    input  logic signed [efr_pkg::CORDIC_W-1:0] up_z,
    input  efr_pkg::vtx_ctl_t                   up_ctl,
    output logic                                down_valid,
    input  logic                                down_ready,
    output logic signed [efr_pkg::CORDIC_W-1:0] down_x,
    output logic signed [efr_pkg::CORDIC_W-1:0] down_y,
    output logic signed [efr_pkg::CORDIC_W-1:0] down_z,
    output efr_pkg::vtx_ctl_t                   down_ctl
);

    import efr_pkg::*;

    logic                       valid_reg;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [CORDIC_W-1:0] z_reg, z_next;
    vtx_ctl_t                   ctl_reg;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] angle;

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        dx    = up_y >>> STAGE;
        dy    = up_x >>> STAGE;
        angle = $signed({1'b0, atan_q30(STAGE)});
        if (!up_z[CORDIC_W-1])
        begin
            x_next = up_x - dx;
            y_next = up_y + dy;
            z_next = up_z - angle;
        end
        else
        begin
            x_next = up_x + dx;
            y_next = up_y - dy;
            z_next = up_z + angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            ctl_reg <= up_ctl;
        end
    end

    assign down_valid = valid_reg;
    assign down_x     = x_reg;
    assign down_y     = y_reg;
    assign down_z     = z_reg;
    assign down_ctl   = ctl_reg;

endmodule

// ===== hw/rtl/ellipse_fan_ring_vertex_gen_unit.sv =====
`timescale 1ns / 1ps
// ellipse triangle fan vertex generator
// input channel: vertex_index with in_valid / in_stall; a transaction moves
// when in_valid is high and in_stall is low. output channel: one vertex per
// input, pos/tex/alpha_clear/bad_request with out_valid / out_stall.
// configuration: cfg_we with cfg_index and cfg_data, one register per write.
// throughput: one vertex per cycle while no setup pass runs and out_stall is low, set by the pipelined cordic chain.
// stages from accept to out_valid: index decode, phase table read, angle scaling,
// one cell per cordic stage, quadrant fold, multiply, round and saturate.
// after reset and after every configuration write a setup pass runs with
// in_stall high: five 40-step divisions on the shared divider, a product
// step, then filling all MAX_SEGMENTS entries of the phase table.
// an out_stall stops only the output register; earlier stages keep filling
// any empty slots, so inputs are taken until the pipeline is full.
// reset clears all valid state and loads the register reset values.
`include "ellipse_fan_ring_vertex_gen_unit_defines.svh"

module ellipse_fan_ring_vertex_gen_unit #(
    parameter int MAX_SEGMENTS  = efr_pkg::MAX_SEGMENTS_DEF,
    parameter int CORDIC_STAGES = efr_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [9:0]         vertex_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] pos_x,
    output logic signed [17:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic signed [15:0] tex_u,
    output logic signed [15:0] tex_v,
    output logic               alpha_clear,
    output logic               bad_request
);

    import efr_pkg::*;

    localparam int AW = $clog2(MAX_SEGMENTS);

    function automatic logic signed [17:0] round_sat18(input logic signed [64:0] p);
        logic signed [64:0] t;
        t = (p + (65'sd1 <<< 37)) >>> 38;
        if (t > 65'sd131071)
        begin
            return 18'sd131071;
        end
        if (t < -65'sd131072)
        begin
            return -18'sd131072;
        end
        return t[17:0];
    endfunction

    function automatic logic signed [15:0] round_sat16(input logic signed [66:0] p);
        logic signed [66:0] t;
        t = (p + (67'sd1 <<< 32)) >>> 33;
        if (t > 67'sd32767)
        begin
            return 16'sd32767;
        end
        if (t < -67'sd32768)
        begin
            return -16'sd32768;
        end
        return t[15:0];
    endfunction

    // configuration registers
    logic [15:0]        w_reg;
    logic [15:0]        h_reg;
    logic [8:0]         n_reg;
    logic [12:0]        b_reg;
    logic signed [15:0] depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg     <= SEMI_WIDTH_RST;
            h_reg     <= SEMI_HEIGHT_RST;
            n_reg     <= SEGMENT_COUNT_RST;
            b_reg     <= FADE_BORDER_RST;
            depth_reg <= DEPTH_VALUE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SEMI_WIDTH:    w_reg     <= cfg_data;
                CFG_SEMI_HEIGHT:   h_reg     <= cfg_data;
                CFG_SEGMENT_COUNT: n_reg     <= cfg_data[8:0];
                CFG_FADE_BORDER:   b_reg     <= cfg_data[12:0];
                CFG_DEPTH_VALUE:   depth_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // setup sequencer
    setup_state_t state_reg, state_next;
    div_job_t     job_reg, job_next;
    logic         div_start;
    logic         div_done;
    logic         fill_we;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [DIV_DEN_W-1:0] div_rem;
    logic [28:0]          border_prod;
    logic [AW-1:0]        fill_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DIV_START;
            job_reg   <= JOB_STEP;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        div_start  = 1'b0;
        fill_we    = 1'b0;
        unique case (state_reg)
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (job_reg == JOB_ADJ_Y)
                    begin
                        state_next = ST_PRODUCT;
                    end
                    else
                    begin
                        job_next   = div_job_t'(job_reg + 3'd1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_PRODUCT:
            begin
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                fill_we = 1'b1;
                if (fill_addr_reg == AW'(MAX_SEGMENTS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_DIV_START;
            end
        endcase
        // new settings restart the whole pass
        if (cfg_we)
        begin
            state_next = ST_DIV_START;
            job_next   = JOB_STEP;
        end
    end

    always_comb
    begin
        border_prod = 29'(b_reg) * 29'((job_reg == JOB_ADJ_X) ? w_reg : h_reg);
        div_num     = '0;
        div_den     = w_reg;
        unique case (job_reg)
            JOB_STEP:
            begin
                div_num = 40'h01_0000_0000;
                div_den = {7'd0, n_reg};
            end
            JOB_ASPECT:
            begin
                div_num = {8'd0, h_reg, 16'd0} + {25'd0, w_reg[15:1]};
            end
            JOB_TWO_B:
            begin
                div_num = {10'd0, b_reg, 17'd0} + {25'd0, w_reg[15:1]};
            end
            JOB_ADJ_X:
            begin
                div_num = {3'd0, border_prod, 8'd0} + {25'd0, h_reg[15:1]};
                div_den = h_reg;
            end
            JOB_ADJ_Y:
            begin
                div_num = {3'd0, border_prod, 8'd0} + {25'd0, w_reg[15:1]};
            end
            default:
            begin
                div_num = '0;
            end
        endcase
    end

    efr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    // values that follow from the settings
    logic [31:0]        q_step_reg;
    logic [8:0]         r_step_reg;
    logic [32:0]        aspect_reg;
    logic signed [31:0] b16_reg;
    logic signed [31:0] ab16_reg;
    logic [30:0]        rx_out_reg;
    logic [30:0]        ry_out_reg;
    logic [37:0]        widened;
    logic signed [65:0] ab_prod;
    logic signed [65:0] ab_round;

    always_comb
    begin
        widened  = {14'd0, ((job_reg == JOB_ADJ_X) ? w_reg : h_reg), 8'd0}
                   + div_quot[37:0];
        ab_prod  = 66'($signed({1'b0, aspect_reg})) * 66'(b16_reg);
        ab_round = (ab_prod + 66'sd32768) >>> 16;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV_WAIT && div_done)
        begin
            unique case (job_reg)
                JOB_STEP:
                begin
                    q_step_reg <= div_quot[31:0];
                    r_step_reg <= div_rem[8:0];
                end
                JOB_ASPECT: aspect_reg <= div_quot[32:0];
                JOB_TWO_B:  b16_reg <= 32'sd65536 - $signed({1'b0, div_quot[30:0]});
                JOB_ADJ_X:  rx_out_reg <= (widened > 38'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                                     : widened[30:0];
                JOB_ADJ_Y:  ry_out_reg <= (widened > 38'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                                     : widened[30:0];
                default:    ;
            endcase
        end
        if (state_reg == ST_PRODUCT)
        begin
            if (ab_round > 66'sd2147483647)
            begin
                ab16_reg <= 32'sh7FFF_FFFF;
            end
            else if (ab_round < -66'sd2147483648)
            begin
                ab16_reg <= 32'sh8000_0000;
            end
            else
            begin
                ab16_reg <= ab_round[31:0];
            end
        end
    end

    // phase table fill: phase(j) = round(j * 2^32 / n), built by stepping
    logic [31:0] acc_q_reg;
    logic [9:0]  acc_r_reg;
    logic [9:0]  r_sum;
    logic        r_wrap;

    always_comb
    begin
        r_sum  = acc_r_reg + {1'b0, r_step_reg};
        r_wrap = r_sum >= {1'b0, n_reg};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PRODUCT)
        begin
            fill_addr_reg <= '0;
            acc_q_reg     <= '0;
            acc_r_reg     <= {2'd0, n_reg[8:1]};
        end
        else if (fill_we)
        begin
            fill_addr_reg <= fill_addr_reg + 1'b1;
            acc_q_reg     <= acc_q_reg + q_step_reg + {31'd0, r_wrap};
            acc_r_reg     <= r_wrap ? r_sum - {1'b0, n_reg} : r_sum;
        end
    end

    // vertex pipeline
    logic        in_acc;
    logic        rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_o;
    logic        va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vo_reg;
    vtx_ctl_t    ctl_a_reg, ctl_b_reg, ctl_c_reg, ctl_d_reg, ctl_e_reg;
    vtx_ctl_t    ctl_in;
    logic [AW-1:0] j_a_reg;
    logic [9:0]  last_index;
    logic [9:0]  j_full;
    logic [31:0] phase;
    logic [60:0] z_prod;

    always_comb
    begin
        last_index    = (b_reg != 13'd0) ? {n_reg, 1'b0} : {1'b0, n_reg};
        ctl_in.bad    = (w_reg == 16'd0) || (h_reg == 16'd0) || (n_reg < 9'd3)
                        || (32'(n_reg) > MAX_SEGMENTS) || (vertex_index > last_index);
        ctl_in.center = vertex_index == 10'd0;
        ctl_in.outer  = vertex_index > {1'b0, n_reg};
        ctl_in.quad   = 2'd0;
        j_full        = ctl_in.outer ? vertex_index - {1'b0, n_reg} - 10'd1
                                     : vertex_index - 10'd1;
    end

    assign rdy_o    = !vo_reg || !out_stall;
    assign rdy_e    = !ve_reg || rdy_o;
    assign rdy_d    = !vd_reg || rdy_e;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_stall = (state_reg != ST_RUN) || !rdy_a;
    assign in_acc   = in_valid && !in_stall;

    efr_ram #(
        .WIDTH (32),
        .DEPTH (MAX_SEGMENTS)
    ) u_phase_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_addr_reg),
        .wdata (acc_q_reg),
        .re    (rdy_b),
        .raddr (j_a_reg),
        .rdata (phase)
    );

    assign z_prod = 61'(phase[29:0]) * 61'(HALF_PI_Q30) + (61'd1 << 29);

    // cordic chain
    logic                       cv   [0:CORDIC_STAGES];
    logic                       crdy [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] cx   [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] cy   [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] cz   [0:CORDIC_STAGES];
    vtx_ctl_t                   cctl [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] z_c_reg;

    assign cv[0]   = vc_reg;
    assign cx[0]   = $signed({1'b0, GAIN_Q30});
    assign cy[0]   = '0;
    assign cz[0]   = z_c_reg;
    assign cctl[0] = ctl_c_reg;
    assign rdy_c   = !vc_reg || crdy[0];
    assign crdy[CORDIC_STAGES] = rdy_d;

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cell
        efr_cordic_cell #(
            .STAGE (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (cv[k]),
            .up_ready   (crdy[k]),
            .up_x       (cx[k]),
            .up_y       (cy[k]),
            .up_z       (cz[k]),
            .up_ctl     (cctl[k]),
            .down_valid (cv[k+1]),
            .down_ready (crdy[k+1]),
            .down_x     (cx[k+1]),
            .down_y     (cy[k+1]),
            .down_z     (cz[k+1]),
            .down_ctl   (cctl[k+1])
        );
    end

    logic signed [CORDIC_W-1:0] cx_end, cy_end, c_next, s_next;
    logic signed [CORDIC_W-1:0] c_d_reg, s_d_reg;
    vtx_ctl_t                   ctl_end;

    assign cx_end  = cx[CORDIC_STAGES];
    assign cy_end  = cy[CORDIC_STAGES];
    assign ctl_end = cctl[CORDIC_STAGES];

    always_comb
    begin
        case (ctl_end.quad)
            2'd0:    begin c_next = cx_end;  s_next = cy_end;  end
            2'd1:    begin c_next = -cy_end; s_next = cx_end;  end
            2'd2:    begin c_next = -cx_end; s_next = -cy_end; end
            default: begin c_next = cy_end;  s_next = -cx_end; end
        endcase
    end

    logic signed [31:0] rx_s, ry_s, ub_s;
    logic signed [33:0] vf_s;
    logic signed [64:0] px_p_reg, py_p_reg;
    logic signed [64:0] tu_p_reg;
    logic signed [66:0] tv_p_reg;

    always_comb
    begin
        rx_s = ctl_d_reg.outer ? $signed({1'b0, rx_out_reg}) : $signed({8'd0, w_reg, 8'd0});
        ry_s = ctl_d_reg.outer ? $signed({1'b0, ry_out_reg}) : $signed({8'd0, h_reg, 8'd0});
        ub_s = ctl_d_reg.outer ? 32'sd65536 : b16_reg;
        vf_s = ctl_d_reg.outer ? $signed({1'b0, aspect_reg})
                               : $signed({{2{ab16_reg[31]}}, ab16_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a) va_reg <= in_acc;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
            if (rdy_d) vd_reg <= cv[CORDIC_STAGES];
            if (rdy_e) ve_reg <= vd_reg;
            if (rdy_o) vo_reg <= ve_reg;
        end
    end

    logic signed [17:0] pos_x_reg, pos_y_reg;
    logic signed [15:0] pos_z_reg, tex_u_reg, tex_v_reg;
    logic               alpha_reg, bad_reg;
    logic               zero_out;

    assign zero_out = ctl_e_reg.bad || ctl_e_reg.center;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ctl_a_reg <= ctl_in;
            j_a_reg   <= j_full[AW-1:0];
        end
        if (rdy_b && va_reg)
        begin
            ctl_b_reg <= ctl_a_reg;
        end
        if (rdy_c && vb_reg)
        begin
            ctl_c_reg <= '{bad: ctl_b_reg.bad, center: ctl_b_reg.center,
                           outer: ctl_b_reg.outer, quad: phase[31:30]};
            z_c_reg   <= $signed({2'b00, z_prod[60:30]});
        end
        if (rdy_d && cv[CORDIC_STAGES])
        begin
            ctl_d_reg <= ctl_end;
            c_d_reg   <= c_next;
            s_d_reg   <= s_next;
        end
        if (rdy_e && vd_reg)
        begin
            ctl_e_reg <= ctl_d_reg;
            px_p_reg  <= 65'(c_d_reg) * 65'(rx_s);
            py_p_reg  <= 65'(s_d_reg) * 65'(ry_s);
            tu_p_reg  <= 65'(c_d_reg) * 65'(ub_s);
            tv_p_reg  <= 67'(s_d_reg) * 67'(vf_s);
        end
        if (rdy_o && ve_reg)
        begin
            pos_x_reg <= zero_out ? 18'sd0 : round_sat18(px_p_reg);
            pos_y_reg <= zero_out ? 18'sd0 : round_sat18(py_p_reg);
            pos_z_reg <= zero_out ? 16'sd0 : depth_reg;
            tex_u_reg <= zero_out ? 16'sd0 : round_sat16(67'(tu_p_reg));
            tex_v_reg <= zero_out ? 16'sd0 : round_sat16(tv_p_reg);
            alpha_reg <= !zero_out && ctl_e_reg.outer;
            bad_reg   <= ctl_e_reg.bad;
        end
    end

    assign out_valid   = vo_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pos_z       = pos_z_reg;
    assign tex_u       = tex_u_reg;
    assign tex_v       = tex_v_reg;
    assign alpha_clear = alpha_reg;
    assign bad_request = bad_reg;

    `EFR_ASSERT_NEXT(a_cfg_restarts_setup, cfg_we, state_reg == ST_DIV_START)
    `EFR_ASSERT_IMPL(a_bad_zero_data, out_valid && bad_request,
        pos_x == 18'sd0 && pos_y == 18'sd0 && pos_z == 16'sd0 && tex_u == 16'sd0
        && tex_v == 16'sd0 && !alpha_clear)
    `EFR_ASSERT_IMPL(a_ring_carries_depth, out_valid && alpha_clear,
        !bad_request && pos_z == depth_reg)
    `EFR_ASSERT(a_no_fill_in_run, !(fill_we && (va_reg || vo_reg)))

endmodule
